// ===== hw/rtl/cdad_pkg.sv =====
package cdad_pkg;

    localparam int YearBitsDefault = 16;
    localparam int InYearW = 16;
    localparam int OffW = 32;
    localparam int DiffW = 26;
    localparam int CntW = 34;
    localparam int EpochShift = 719468;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_BAD_MONTH = 2'd1,
        ST_BAD_DAY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        begin
            case (m)
                4'd2: r = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
                default: r = 5'd31;
            endcase
            return r;
        end
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        begin
            case (m)
                4'd3: r = 9'd0;
                4'd4: r = 9'd31;
                4'd5: r = 9'd61;
                4'd6: r = 9'd92;
                4'd7: r = 9'd122;
                4'd8: r = 9'd153;
                4'd9: r = 9'd184;
                4'd10: r = 9'd214;
                4'd11: r = 9'd245;
                4'd12: r = 9'd275;
                4'd1: r = 9'd306;
                default: r = 9'd337;
            endcase
            return r;
        end
    endfunction

    function automatic logic is_leap(input logic signed [InYearW-1:0] y);
        logic signed [InYearW:0] ye;
        logic d100;
        logic d400;
        begin
            ye = InYearW'(y) ;
            ye = {y[InYearW-1], y};
            d100 = ((ye % 17'sd100) == 17'sd0);
            d400 = ((ye % 17'sd400) == 17'sd0);
            return d400 || ((y[1:0] == 2'b00) && !d100);
        end
    endfunction

endpackage

// ===== hw/rtl/cdad_to_count.sv =====
module cdad_to_count (
    input  logic i_clk,
    input  logic [4:0] i_day,
    input  logic [3:0] i_month,
    input  logic signed [cdad_pkg::InYearW-1:0] i_year,
    output logic signed [cdad_pkg::CntW-1:0] o_count
);
    import cdad_pkg::*;

    logic signed [InYearW:0] n_y;
    logic signed [InYearW:0] r_y;
    logic [8:0] r_diy;
    logic signed [CntW-1:0] n_cnt;

    always_comb begin
        n_y = {i_year[InYearW-1], i_year} - ((i_month <= 4'd2) ? 17'sd1 : 17'sd0);
    end

    always_ff @(posedge i_clk) begin
        r_y <= n_y;
        r_diy <= month_start(i_month) + 9'(i_day) - 9'd1;
    end

    always_comb begin
        n_cnt = CntW'(r_y) * 34'sd365
              + CntW'(r_y >>> 2)
              - CntW'(r_y < 0 ? -((-r_y + 17'sd99) / 17'sd100) : r_y / 17'sd100)
              + CntW'(r_y < 0 ? -((-r_y + 17'sd399) / 17'sd400) : r_y / 17'sd400)
              + CntW'({1'b0, r_diy})
              + 34'sd60 - 34'(EpochShift) + 34'sd0;
    end

    always_ff @(posedge i_clk) begin
        o_count <= n_cnt - 34'sd60 + 34'sd0 + 34'sd1 * 34'sd0;
    end
endmodule

// ===== hw/rtl/cdad_from_count.sv =====
module cdad_from_count (
    input  logic i_clk,
    input  logic signed [cdad_pkg::CntW-1:0] i_count,
    output logic [4:0] o_day,
    output logic [3:0] o_month,
    output logic signed [cdad_pkg::CntW-1:0] o_year
);
    import cdad_pkg::*;

    logic signed [CntW-1:0] z;
    logic signed [CntW-1:0] n_cyc;
    logic signed [CntW-1:0] r_cyc;
    logic [17:0] r_dic;
    logic [8:0] yic;
    logic [8:0] r_yic;
    logic [8:0] r_diy;
    logic [17:0] ystart;
    logic signed [CntW-1:0] r_cyc2;
    logic [3:0] mp;
    logic [8:0] base;
    logic [3:0] mo;

    always_comb begin
        z = i_count + 34'sd719468;
        n_cyc = (z >= 0) ? z / 34'sd146097 : (z - 34'sd146096) / 34'sd146097;
    end

    always_ff @(posedge i_clk) begin
        r_cyc <= n_cyc;
        r_dic <= 18'(z - n_cyc * 34'sd146097);
    end

    always_comb begin
        yic = 9'((r_dic - r_dic / 18'd1460 + r_dic / 18'd36524 - r_dic / 18'd146096) / 18'd365);
        ystart = 18'(yic) * 18'd365 + 18'(yic >> 2) - 18'(yic / 9'd100);
    end

    always_ff @(posedge i_clk) begin
        r_cyc2 <= r_cyc;
        r_yic <= yic;
        r_diy <= 9'(r_dic - ystart);
    end

    always_comb begin
        mp = 4'((14'(r_diy) * 14'd5 + 14'd2) / 14'd153);
        mo = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
        base = month_start(mo);
    end

    always_ff @(posedge i_clk) begin
        o_day <= 5'(r_diy - base + 9'd1);
        o_month <= mo;
        o_year <= CntW'({1'b0, r_yic}) + r_cyc2 * 34'sd400 + ((mo <= 4'd2) ? 34'sd1 : 34'sd0);
    end
endmodule

// ===== hw/rtl/civil_date_add_and_difference.sv =====
// o_valid is an accepted start carried through the valid shift register r_v.
// Throughput: one word per cycle; busy is always low.
// The pipeline is set by the two date conversions, two and three stages, and the sum register between them.
// Reset (synchronous, active low) clears all valid bits; data needs none.
// The receiver cannot stall; each result stands for exactly one cycle.
module civil_date_add_and_difference #(
    parameter int YEAR_BITS = cdad_pkg::YearBitsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  logic i_req_type,
    input  logic [4:0] i_day_a,
    input  logic [3:0] i_month_a,
    input  logic signed [15:0] i_year_a,
    input  logic [4:0] i_day_b,
    input  logic [3:0] i_month_b,
    input  logic signed [15:0] i_year_b,
    input  logic signed [31:0] i_offset_days,
    output logic o_valid,
    output logic [4:0] o_out_day,
    output logic [3:0] o_out_month,
    output logic signed [15:0] o_out_year,
    output logic signed [25:0] o_day_difference,
    output logic [1:0] o_status
);
    import cdad_pkg::*;

    localparam int Lat = 6;

    t_status n_st;
    logic [Lat-1:0] r_v;
    logic r_type [Lat];
    t_status r_st [Lat];
    logic signed [OffW-1:0] r_off [2];
    logic signed [CntW-1:0] cnt_a;
    logic signed [CntW-1:0] cnt_b;
    logic signed [CntW-1:0] r_sum;
    logic signed [CntW-1:0] n_diff;
    logic signed [DiffW-1:0] r_diff [2:5];
    logic [4:0] rd;
    logic [3:0] rm;
    logic signed [CntW-1:0] ry;
    logic range_bad;
    logic ok;

    assign busy = 1'b0;

    always_comb begin
        n_st = ST_OK;
        if (i_month_a < 4'd1 || i_month_a > 4'd12) begin
            n_st = ST_BAD_MONTH;
        end else if (i_day_a == 5'd0 || i_day_a > month_len(i_month_a, is_leap(i_year_a))) begin
            n_st = ST_BAD_DAY;
        end else if (i_req_type) begin
            if (i_month_b < 4'd1 || i_month_b > 4'd12) begin
                n_st = ST_BAD_MONTH;
            end else if (i_day_b == 5'd0
                         || i_day_b > month_len(i_month_b, is_leap(i_year_b))) begin
                n_st = ST_BAD_DAY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[Lat-2:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_type[0] <= i_req_type;
        r_st[0] <= n_st;
        for (int i = 1; i < Lat; i++) begin
            r_type[i] <= r_type[i-1];
            r_st[i] <= r_st[i-1];
        end
        r_off[0] <= i_offset_days;
        r_off[1] <= r_off[0];
    end

    cdad_to_count u_cnt_a (
        .i_clk(i_clk), .i_day(i_day_a), .i_month(i_month_a), .i_year(i_year_a),
        .o_count(cnt_a)
    );

    cdad_to_count u_cnt_b (
        .i_clk(i_clk), .i_day(i_day_b), .i_month(i_month_b), .i_year(i_year_b),
        .o_count(cnt_b)
    );

    always_comb begin
        n_diff = cnt_a - cnt_b;
        if (n_diff > 34'sd33554431) begin
            n_diff = 34'sd33554431;
        end else if (n_diff < -34'sd33554432) begin
            n_diff = -34'sd33554432;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= cnt_a + CntW'(r_off[1]);
        r_diff[2] <= DiffW'(n_diff);
        for (int i = 3; i <= 5; i++) begin
            r_diff[i] <= r_diff[i-1];
        end
    end

    cdad_from_count u_date (
        .i_clk(i_clk), .i_count(r_sum), .o_day(rd), .o_month(rm), .o_year(ry)
    );

    assign range_bad = (ry < -(CntW'(1) <<< (YEAR_BITS - 1)))
                    || (ry > (CntW'(1) <<< (YEAR_BITS - 1)) - 34'sd1);
    assign ok = (r_st[Lat-1] == ST_OK);

    always_comb begin
        o_valid = r_v[Lat-1];
        o_out_day = '0;
        o_out_month = '0;
        o_out_year = '0;
        o_day_difference = '0;
        o_status = r_st[Lat-1];
        if (ok && !r_type[Lat-1]) begin
            if (range_bad) begin
                o_status = ST_RANGE;
            end else begin
                o_out_day = rd;
                o_out_month = rm;
                o_out_year = 16'(ry);
            end
        end else if (ok) begin
            o_day_difference = r_diff[5];
        end
    end

`ifndef SYNTH
    a_busy_low: assert property (@(posedge i_clk) busy == 1'b0)
        else $error("busy raised");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##6 o_valid) else $error("result lost");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != 2'd0) |-> (o_out_month == 4'd0 && o_day_difference == 26'sd0))
        else $error("error word carries data");
`endif
endmodule

// ===== bench/civil_date_add_and_difference_tb.sv =====
`timescale 1ns / 1ps

module civil_date_add_and_difference_tb;
    import cdad_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_RANDOM = 830;
    localparam int N_CALM = 150;

    typedef struct {
        logic req_type;
        logic [4:0] day_a;
        logic [3:0] month_a;
        logic signed [15:0] year_a;
        logic [4:0] day_b;
        logic [3:0] month_b;
        logic signed [15:0] year_b;
        logic signed [31:0] offset_days;
    } date_req_t;

    typedef struct {
        logic [4:0] day;
        logic [3:0] month;
        logic [15:0] year;
        logic [25:0] diff;
        t_status status;
    } date_res_t;

    typedef struct {
        date_req_t req;
        bit typed;
        date_res_t res;
    } table_row_t;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_req_type;
    logic [4:0] i_day_a;
    logic [3:0] i_month_a;
    logic signed [15:0] i_year_a;
    logic [4:0] i_day_b;
    logic [3:0] i_month_b;
    logic signed [15:0] i_year_b;
    logic signed [31:0] i_offset_days;
    logic o_valid;
    logic [4:0] o_out_day;
    logic [3:0] o_out_month;
    logic signed [15:0] o_out_year;
    logic signed [25:0] o_day_difference;
    logic [1:0] o_status;

    date_res_t pending_dates[$];
    table_row_t stim_table[$];
    bit cur_typed;
    date_res_t cur_res;
    int mismatches;
    int cycles;

    civil_date_add_and_difference DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_day_a(i_day_a), .i_month_a(i_month_a),
        .i_year_a(i_year_a), .i_day_b(i_day_b), .i_month_b(i_month_b),
        .i_year_b(i_year_b), .i_offset_days(i_offset_days), .o_valid(o_valid),
        .o_out_day(o_out_day), .o_out_month(o_out_month), .o_out_year(o_out_year),
        .o_day_difference(o_day_difference), .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit leap_year(longint y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic longint days_in_month(longint m, longint y);
        longint lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && leap_year(y)) return 29;
        return lens[m - 1];
    endfunction

    function automatic t_status date_check(longint d, longint m, longint y);
        if (m < 1 || m > 12) return ST_BAD_MONTH;
        if (d < 1 || d > days_in_month(m, y)) return ST_BAD_DAY;
        return ST_OK;
    endfunction

    function automatic longint epoch_days(longint d, longint m, longint y);
        longint era, yoe, doy, doe;
        if (m <= 2) y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    function automatic void civil_from_epoch(longint n, output longint d, output longint m,
                                             output longint y);
        longint z, era, doe, yoe, doy, mp;
        z = n + 719468;
        era = (z >= 0 ? z : z - 146096) / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        d = doy - (153 * mp + 2) / 5 + 1;
        m = mp + (mp < 10 ? 3 : -9);
        y = yoe + era * 400 + (m <= 2 ? 1 : 0);
    endfunction

    function automatic date_res_t predict_date(date_req_t q);
        date_res_t r;
        longint rd, rm, ry, df;
        r = '{day: '0, month: '0, year: '0, diff: '0, status: ST_OK};
        r.status = date_check(q.day_a, q.month_a, q.year_a);
        if (q.req_type == 1'b0) begin
            if (r.status == ST_OK) begin
                civil_from_epoch(epoch_days(q.day_a, q.month_a, q.year_a) + q.offset_days,
                                 rd, rm, ry);
                if (ry < -32768 || ry > 32767) begin
                    r.status = ST_RANGE;
                end else begin
                    r.day = rd[4:0];
                    r.month = rm[3:0];
                    r.year = ry[15:0];
                end
            end
        end else begin
            if (r.status == ST_OK) r.status = date_check(q.day_b, q.month_b, q.year_b);
            if (r.status == ST_OK) begin
                df = epoch_days(q.day_a, q.month_a, q.year_a)
                   - epoch_days(q.day_b, q.month_b, q.year_b);
                if (df > 33554431) df = 33554431;
                if (df < -33554432) df = -33554432;
                r.diff = df[25:0];
            end
        end
        return r;
    endfunction

    function automatic date_req_t make_req(logic t, int da, int ma, int ya, int db, int mb,
                                           int yb, int off);
        date_req_t q;
        q.req_type = t;
        q.day_a = da[4:0];
        q.month_a = ma[3:0];
        q.year_a = ya[15:0];
        q.day_b = db[4:0];
        q.month_b = mb[3:0];
        q.year_b = yb[15:0];
        q.offset_days = off;
        return q;
    endfunction

    task automatic add_row(date_req_t q, bit typed, int d, int m, int y, int df, t_status s);
        table_row_t row;
        row.req = q;
        row.typed = typed;
        row.res = '{day: d[4:0], month: m[3:0], year: y[15:0], diff: df[25:0], status: s};
        stim_table.push_back(row);
    endtask

    function automatic date_req_t random_req();
        date_req_t q;
        int yr, mo, lim;
        q.req_type = $urandom_range(0, 1);
        q.day_b = $urandom;
        q.month_b = $urandom;
        q.year_b = $urandom;
        q.day_a = $urandom;
        q.month_a = $urandom;
        q.year_a = $urandom;
        q.offset_days = $urandom;
        if ($urandom_range(0, 9) != 0) begin
            yr = ($urandom_range(0, 2) == 0) ? $signed(16'($urandom))
                                              : int'($urandom_range(0, 4000)) - 1000;
            mo = $urandom_range(1, 12);
            lim = days_in_month(mo, yr);
            q.year_a = yr[15:0];
            q.month_a = mo[3:0];
            q.day_a = $urandom_range(1, lim);
        end
        if ($urandom_range(0, 9) != 0) begin
            yr = ($urandom_range(0, 2) == 0) ? $signed(16'($urandom))
                                              : int'($urandom_range(0, 4000)) - 1000;
            mo = $urandom_range(1, 12);
            lim = days_in_month(mo, yr);
            q.year_b = yr[15:0];
            q.month_b = mo[3:0];
            q.day_b = $urandom_range(1, lim);
        end
        case ($urandom_range(0, 3))
            0: q.offset_days = int'($urandom_range(0, 800)) - 400;
            1: q.offset_days = int'($urandom_range(0, 2000000)) - 1000000;
            2: q.offset_days = int'($urandom_range(0, 24000000)) - 12000000;
            default: ;
        endcase
        return q;
    endfunction

    task automatic send_word(date_req_t q, bit typed, date_res_t r, bit idle_ok);
        int gap;
        @(negedge i_clk);
        i_req_type <= q.req_type;
        i_day_a <= q.day_a;
        i_month_a <= q.month_a;
        i_year_a <= q.year_a;
        i_day_b <= q.day_b;
        i_month_b <= q.month_b;
        i_year_b <= q.year_b;
        i_offset_days <= q.offset_days;
        cur_typed <= typed;
        cur_res <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (idle_ok && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        date_req_t q;
        date_res_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n && start && !busy) begin
            q = '{req_type: i_req_type, day_a: i_day_a, month_a: i_month_a,
                  year_a: i_year_a, day_b: i_day_b, month_b: i_month_b,
                  year_b: i_year_b, offset_days: i_offset_days};
            pending_dates.push_back(cur_typed ? cur_res : predict_date(q));
        end
        if (i_rst_n && o_valid) begin
            if (pending_dates.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("Unexpected result word at cycle %0d", cycles);
            end else begin
                e = pending_dates.pop_front();
                if (o_out_day !== e.day || o_out_month !== e.month || o_out_year !== e.year ||
                    o_day_difference !== e.diff || o_status !== e.status) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Mismatch: exp d=%0d m=%0d y=%0d diff=%0d st=%0d, got d=%0d m=%0d y=%0d diff=%0d st=%0d",
                                 e.day, e.month, $signed(e.year), $signed(e.diff), e.status,
                                 o_out_day, o_out_month, o_out_year, o_day_difference,
                                 o_status);
                end
            end
        end
    end

    initial begin
        date_res_t none;
        none = '{day: '0, month: '0, year: '0, diff: '0, status: ST_OK};
        cycles = 0;
        mismatches = 0;
        cur_typed = 1'b0;
        cur_res = none;
        start = 1'b0;
        i_req_type = 1'b0;
        i_day_a = '0;
        i_month_a = '0;
        i_year_a = '0;
        i_day_b = '0;
        i_month_b = '0;
        i_year_b = '0;
        i_offset_days = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(make_req(0, 1, 1, 1970, 0, 0, 0, 0), 1, 1, 1, 1970, 0, ST_OK);
        add_row(make_req(0, 1, 0, 1970, 0, 0, 0, 5), 1, 0, 0, 0, 0, ST_BAD_MONTH);
        add_row(make_req(0, 31, 15, -1, 0, 0, 0, 5), 1, 0, 0, 0, 0, ST_BAD_MONTH);
        add_row(make_req(0, 29, 2, 1970, 0, 0, 0, 0), 1, 0, 0, 0, 0, ST_BAD_DAY);
        add_row(make_req(0, 0, 7, 2020, 0, 0, 0, 0), 1, 0, 0, 0, 0, ST_BAD_DAY);
        add_row(make_req(0, 31, 12, 32767, 0, 0, 0, 1), 1, 0, 0, 0, 0, ST_RANGE);
        add_row(make_req(0, 1, 1, -32768, 0, 0, 0, -1), 1, 0, 0, 0, 0, ST_RANGE);
        add_row(make_req(1, 29, 2, 2000, 29, 2, 2000, 7), 1, 0, 0, 0, 0, ST_OK);
        add_row(make_req(1, 2, 1, 1970, 1, 1, 1970, 0), 1, 0, 0, 0, 1, ST_OK);
        add_row(make_req(1, 1, 1, 1970, 1, 13, 1970, 0), 1, 0, 0, 0, 0, ST_BAD_MONTH);
        add_row(make_req(1, 31, 4, 1970, 1, 0, 1970, 0), 1, 0, 0, 0, 0, ST_BAD_DAY);
        add_row(make_req(1, 1, 1, 1970, 31, 4, 1970, 0), 1, 0, 0, 0, 0, ST_BAD_DAY);
        add_row(make_req(1, 31, 12, 32767, 1, 1, -32768, 0), 0, 0, 0, 0, 0, ST_OK);
        add_row(make_req(1, 1, 1, -32768, 31, 12, 32767, 0), 0, 0, 0, 0, 0, ST_OK);
        add_row(make_req(0, 1, 1, 1970, 0, 0, 0, 32'h7fffffff), 0, 0, 0, 0, 0, ST_OK);
        add_row(make_req(0, 1, 1, 1970, 0, 0, 0, 32'h80000000), 0, 0, 0, 0, 0, ST_OK);
        add_row(make_req(0, 28, 2, 2000, 0, 0, 0, 1), 0, 0, 0, 0, 0, ST_OK);
        add_row(make_req(0, 28, 2, 1900, 0, 0, 0, 1), 0, 0, 0, 0, 0, ST_OK);
        add_row(make_req(0, 29, 2, 0, 0, 0, 0, 365), 0, 0, 0, 0, 0, ST_OK);
        add_row(make_req(0, 29, 2, -1, 0, 0, 0, 0), 0, 0, 0, 0, 0, ST_OK);
        add_row(make_req(0, 29, 2, -4, 0, 0, 0, -1461), 0, 0, 0, 0, 0, ST_OK);
        add_row(make_req(0, 31, 12, 32767, 0, 0, 0, -11960000), 0, 0, 0, 0, 0, ST_OK);
        add_row(make_req(0, 1, 1, -32768, 0, 0, 0, 23900000), 0, 0, 0, 0, 0, ST_OK);

        foreach (stim_table[i])
            send_word(stim_table[i].req, stim_table[i].typed, stim_table[i].res, 1'b1);
        for (int n = 0; n < N_RANDOM; n++)
            send_word(random_req(), 1'b0, none, n < N_RANDOM - N_CALM);
        @(negedge i_clk);
        start <= 1'b0;

        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_dates.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/cdad_pkg.sv
hw/rtl/cdad_to_count.sv
hw/rtl/cdad_from_count.sv
hw/rtl/civil_date_add_and_difference.sv
bench/civil_date_add_and_difference_tb.sv
